FILE: src/ohm_pkg.sv
// Shared types, constants and hash step function for the open addressing hash map.
package ohm_pkg;

    localparam int MAX_SLOTS = 1024;
    localparam int MIN_SLOTS = 8;
    localparam int KEY_BYTES = 8;
    localparam int IDX_W = $clog2(MAX_SLOTS);
    localparam int ADDR_W = IDX_W + 1;
    localparam int SIZE_W = IDX_W + 1;
    localparam int CLR_W = ADDR_W + 1;
    localparam int CNT_W = $clog2(KEY_BYTES + 1);
    localparam int BYTE_W = $clog2(KEY_BYTES);

    localparam logic [1:0] CMD_SET = 2'd0;
    localparam logic [1:0] CMD_GET = 2'd1;
    localparam logic [1:0] CMD_DEL = 2'd2;
    localparam logic [1:0] CMD_NEXT = 2'd3;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_MISSING = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;

    localparam logic [1:0] MARK_EMPTY = 2'd0;
    localparam logic [1:0] MARK_LIVE = 2'd1;
    localparam logic [1:0] MARK_TOMB = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [63:0] key;
        logic [63:0] value;
        logic [31:0] hash;
    } t_req;

    typedef struct packed {
        logic [1:0]  mark;
        logic [31:0] hash;
        logic [63:0] key;
        logic [63:0] data;
    } t_entry;

    // One round of the shifting string hash; the right shift is arithmetic.
    function automatic logic [31:0] hash_step(input logic [31:0] h, input logic [7:0] b);
        logic [31:0] sr;
        sr = {h[31], h[31], h[31:2]};
        return h ^ ((h << 5) + sr + {24'b0, b});
    endfunction

endpackage

FILE: src/ohm_ram.sv
// Generic simple dual-port RAM with registered read.
module ohm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: src/ohm_front.sv
// Front end: accepts requests and hashes the key one byte per cycle.
module ohm_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [1:0]    i_cmd,
    input  logic [63:0]   i_key,
    input  logic [63:0]   i_value,
    output logic          o_full,
    input  logic          i_q_full,
    output logic          o_q_wr,
    output ohm_pkg::t_req o_q_data
);
    logic                      r_busy;
    logic [ohm_pkg::CNT_W-1:0] r_cnt;
    logic [1:0]                r_cmd;
    logic [63:0]               r_key;
    logic [63:0]               r_value;
    logic [31:0]               r_hash;
    logic [ohm_pkg::BYTE_W-1:0] byte_idx;

    assign byte_idx = ohm_pkg::BYTE_W'(r_cnt - 1'b1);
    assign o_full = r_busy;
    assign o_q_wr = r_busy && (r_cnt == '0) && !i_q_full;
    assign o_q_data = '{cmd: r_cmd, key: r_key, value: r_value, hash: r_hash};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt <= '0;
        end else if (!r_busy) begin
            if (i_push) begin
                r_busy <= 1'b1;
                r_cnt <= ohm_pkg::CNT_W'(ohm_pkg::KEY_BYTES);
                r_cmd <= i_cmd;
                r_key <= i_key;
                r_value <= i_value;
                r_hash <= 32'(ohm_pkg::KEY_BYTES) + i_key[31:0];
            end
        end else if (r_cnt != '0) begin
            // Bytes are folded in from the most significant one down.
            r_hash <= ohm_pkg::hash_step(r_hash, r_key[{byte_idx, 3'b000} +: 8]);
            r_cnt <= r_cnt - 1'b1;
        end else if (o_q_wr) begin
            r_busy <= 1'b0;
        end
    end
endmodule

FILE: src/ohm_queue.sv
// Two-entry request queue between the front end and the table engine.
module ohm_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  ohm_pkg::t_req i_wdata,
    output logic          o_full,
    input  logic          i_rd,
    output logic          o_valid,
    output ohm_pkg::t_req o_rdata
);
    ohm_pkg::t_req r_mem [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_count;

    assign o_full = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_rdata = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_wdata;
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_wr) begin
                r_wp <= ~r_wp;
            end
            if (i_rd) begin
                r_rp <= ~r_rp;
            end
            r_count <= r_count + {1'b0, i_wr} - {1'b0, i_rd};
        end
    end
endmodule

FILE: src/ohm_back.sv
// Table engine: probes, inserts, deletes, walks the cursor and rehashes between banks.
module ohm_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    output logic                      o_init,
    input  logic                      i_q_valid,
    input  ohm_pkg::t_req             i_q_data,
    output logic                      o_q_rd,
    output logic                      o_valid,
    input  logic                      i_pop,
    output logic [1:0]                o_status,
    output logic [ohm_pkg::IDX_W-1:0] o_slot,
    output logic [63:0]               o_out_key,
    output logic [63:0]               o_out_value,
    output logic [ohm_pkg::SIZE_W-1:0] o_live_entries
);
    localparam int IW = ohm_pkg::IDX_W;
    localparam int SW = ohm_pkg::SIZE_W;

    localparam logic [3:0] S_CLR = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_FIND_RD = 4'd2;
    localparam logic [3:0] S_FIND_CHK = 4'd3;
    localparam logic [3:0] S_MISS = 4'd4;
    localparam logic [3:0] S_INS_RD = 4'd5;
    localparam logic [3:0] S_INS_CHK = 4'd6;
    localparam logic [3:0] S_RH_RD = 4'd7;
    localparam logic [3:0] S_RH_CHK = 4'd8;
    localparam logic [3:0] S_NXT_RD = 4'd9;
    localparam logic [3:0] S_NXT_CHK = 4'd10;
    localparam logic [3:0] S_DONE = 4'd11;

    logic [3:0]                 r_state;
    logic                       r_init;
    logic [ohm_pkg::CLR_W-1:0]  r_cnt;
    logic                       r_bank;
    logic                       r_old_bank;
    logic [SW-1:0]              r_size;
    logic [SW-1:0]              r_old_size;
    logic [SW-1:0]              r_live;
    logic [SW-1:0]              r_occ;
    logic [IW-1:0]              r_cursor;
    logic [SW-1:0]              r_j;
    logic [SW-1:0]              r_k;
    logic [IW-1:0]              r_pidx;
    logic                       r_moving;
    logic [1:0]                 r_cmd;
    logic [31:0]                r_h;
    logic [63:0]                r_key;
    logic [63:0]                r_val;
    logic [31:0]                r_ih;
    logic [63:0]                r_ik;
    logic [63:0]                r_iv;
    logic [1:0]                 r_status;
    logic [IW-1:0]              r_slot;
    logic [63:0]                r_okey;
    logic [63:0]                r_oval;
    logic                       r_out_valid;
    logic [1:0]                 r_out_status;
    logic [IW-1:0]              r_out_slot;
    logic [63:0]                r_out_key;
    logic [63:0]                r_out_value;
    logic [SW-1:0]              r_out_live;

    logic [IW-1:0]              mask;
    logic [IW-1:0]              probe;
    logic [IW-1:0]              cur_inc;
    logic [ohm_pkg::CLR_W-1:0]  clr_end;
    logic [SW+1:0]              occ_lim;
    logic [SW:0]                grown;
    logic                       hit;
    logic                       ram_we;
    logic [ohm_pkg::ADDR_W-1:0] ram_waddr;
    logic [ohm_pkg::ADDR_W-1:0] ram_raddr;
    ohm_pkg::t_entry            ram_wdata;
    ohm_pkg::t_entry            rd;

    assign mask = IW'(r_size - 1'b1);
    assign probe = (r_ih[IW-1:0] + r_j[IW-1:0]) & mask;
    assign cur_inc = (r_cursor + 1'b1) & mask;
    assign clr_end = r_init ? ohm_pkg::CLR_W'(2 * ohm_pkg::MAX_SLOTS)
                            : ohm_pkg::CLR_W'(r_size);
    assign occ_lim = ((SW+2)'(r_size) * (SW+2)'(3)) >> 2;
    assign grown = {r_size, 1'b0};
    assign hit = (rd.mark == ohm_pkg::MARK_LIVE) && (rd.hash == r_h) && (rd.key == r_key);

    assign o_init = r_init;
    assign o_q_rd = (r_state == S_IDLE) && i_q_valid && !r_out_valid;
    assign o_valid = r_out_valid;
    assign o_status = r_out_status;
    assign o_slot = r_out_slot;
    assign o_out_key = r_out_key;
    assign o_out_value = r_out_value;
    assign o_live_entries = r_out_live;

    ohm_ram #(
        .WIDTH($bits(ohm_pkg::t_entry)),
        .DEPTH(2 * ohm_pkg::MAX_SLOTS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(rd)
    );

    always_comb begin
        ram_we = 1'b0;
        ram_waddr = {r_bank, r_pidx};
        ram_wdata = '{mark: ohm_pkg::MARK_LIVE, hash: r_ih, key: r_ik, data: r_iv};
        ram_raddr = {r_bank, probe};
        unique case (r_state)
            S_CLR: begin
                ram_we = 1'b1;
                ram_waddr = r_init ? r_cnt[ohm_pkg::ADDR_W-1:0] : {r_bank, r_cnt[IW-1:0]};
                ram_wdata = '{mark: ohm_pkg::MARK_EMPTY, hash: '0, key: '0, data: '0};
            end
            S_FIND_CHK: begin
                if (hit && r_cmd == ohm_pkg::CMD_SET) begin
                    ram_we = 1'b1;
                    ram_wdata = '{mark: ohm_pkg::MARK_LIVE, hash: rd.hash, key: rd.key,
                                  data: r_val};
                end else if (hit && r_cmd == ohm_pkg::CMD_DEL) begin
                    ram_we = 1'b1;
                    ram_wdata = '{mark: ohm_pkg::MARK_TOMB, hash: rd.hash, key: rd.key,
                                  data: rd.data};
                end
            end
            S_INS_CHK: begin
                ram_we = (rd.mark != ohm_pkg::MARK_LIVE);
            end
            S_RH_RD: begin
                ram_raddr = {r_old_bank, r_k[IW-1:0]};
            end
            S_NXT_RD: begin
                ram_raddr = {r_bank, cur_inc};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_init <= 1'b1;
            r_cnt <= '0;
            r_bank <= 1'b0;
            r_size <= SW'(ohm_pkg::MIN_SLOTS);
            r_live <= '0;
            r_occ <= '0;
            r_cursor <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_pop) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLR: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == clr_end - 1'b1) begin
                        r_cnt <= '0;
                        r_k <= '0;
                        r_init <= 1'b0;
                        r_state <= r_init ? S_IDLE : S_RH_RD;
                    end
                end
                S_IDLE: begin
                    if (o_q_rd) begin
                        r_cmd <= i_q_data.cmd;
                        r_h <= i_q_data.hash;
                        r_key <= i_q_data.key;
                        r_val <= i_q_data.value;
                        r_ih <= i_q_data.hash;
                        r_ik <= i_q_data.key;
                        r_iv <= i_q_data.value;
                        r_j <= '0;
                        r_moving <= 1'b0;
                        r_status <= ohm_pkg::ST_OK;
                        r_slot <= '0;
                        r_okey <= '0;
                        r_oval <= '0;
                        if (i_q_data.cmd != ohm_pkg::CMD_NEXT) begin
                            r_state <= S_FIND_RD;
                        end else if (r_live == '0) begin
                            r_status <= ohm_pkg::ST_EMPTY;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_NXT_RD;
                        end
                    end
                end
                S_FIND_RD: begin
                    r_pidx <= probe;
                    r_state <= (r_j == r_size) ? S_MISS : S_FIND_CHK;
                end
                S_FIND_CHK: begin
                    if (rd.mark == ohm_pkg::MARK_EMPTY) begin
                        r_state <= S_MISS;
                    end else if (hit) begin
                        r_slot <= r_pidx;
                        if (r_cmd == ohm_pkg::CMD_GET) begin
                            r_oval <= rd.data;
                        end
                        if (r_cmd == ohm_pkg::CMD_DEL) begin
                            r_live <= r_live - 1'b1;
                        end
                        r_state <= S_DONE;
                    end else begin
                        r_j <= r_j + 1'b1;
                        r_state <= S_FIND_RD;
                    end
                end
                S_MISS: begin
                    r_j <= '0;
                    if (r_cmd != ohm_pkg::CMD_SET) begin
                        r_status <= ohm_pkg::ST_MISSING;
                        r_state <= S_DONE;
                    end else if (r_live >= (r_size >> 1) || (SW+2)'(r_occ) >= occ_lim) begin
                        // Rehash to the other bank; double when half live and not at max.
                        r_old_bank <= r_bank;
                        r_old_size <= r_size;
                        r_bank <= ~r_bank;
                        if (r_live >= (r_size >> 1) && grown <= (SW+1)'(ohm_pkg::MAX_SLOTS)) begin
                            r_size <= SW'(grown);
                        end
                        r_live <= '0;
                        r_occ <= '0;
                        r_cnt <= '0;
                        r_state <= S_CLR;
                    end else begin
                        r_state <= S_INS_RD;
                    end
                end
                S_INS_RD: begin
                    r_pidx <= probe;
                    if (r_j == r_size) begin
                        if (r_moving) begin
                            r_state <= S_RH_RD;
                        end else begin
                            r_status <= ohm_pkg::ST_FULL;
                            r_state <= S_DONE;
                        end
                    end else begin
                        r_state <= S_INS_CHK;
                    end
                end
                S_INS_CHK: begin
                    if (rd.mark == ohm_pkg::MARK_LIVE) begin
                        r_j <= r_j + 1'b1;
                        r_state <= S_INS_RD;
                    end else begin
                        if (rd.mark == ohm_pkg::MARK_EMPTY) begin
                            r_occ <= r_occ + 1'b1;
                        end
                        r_live <= r_live + 1'b1;
                        r_slot <= r_pidx;
                        r_state <= r_moving ? S_RH_RD : S_DONE;
                    end
                end
                S_RH_RD: begin
                    if (r_k == r_old_size) begin
                        r_ih <= r_h;
                        r_ik <= r_key;
                        r_iv <= r_val;
                        r_j <= '0;
                        r_moving <= 1'b0;
                        r_state <= S_INS_RD;
                    end else begin
                        r_state <= S_RH_CHK;
                    end
                end
                S_RH_CHK: begin
                    r_k <= r_k + 1'b1;
                    if (rd.mark == ohm_pkg::MARK_LIVE) begin
                        r_ih <= rd.hash;
                        r_ik <= rd.key;
                        r_iv <= rd.data;
                        r_j <= '0;
                        r_moving <= 1'b1;
                        r_state <= S_INS_RD;
                    end else begin
                        r_state <= S_RH_RD;
                    end
                end
                S_NXT_RD: begin
                    r_cursor <= cur_inc;
                    r_state <= S_NXT_CHK;
                end
                S_NXT_CHK: begin
                    if (rd.mark == ohm_pkg::MARK_LIVE) begin
                        r_slot <= r_cursor;
                        r_okey <= rd.key;
                        r_oval <= rd.data;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_NXT_RD;
                    end
                end
                S_DONE: begin
                    r_out_valid <= 1'b1;
                    r_out_status <= r_status;
                    r_out_slot <= (r_status == ohm_pkg::ST_OK) ? r_slot : '0;
                    r_out_key <= r_okey;
                    r_out_value <= r_oval;
                    r_out_live <= r_live;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule

FILE: src/open_addressing_hash_map_top.sv
// Top level of the open addressing hash map: front end, request queue and table engine.
// A request is hashed by the front end, one key byte per cycle, and then waits in a
// two-entry queue. The table engine reads one slot at a time through the single read
// port of the slot memory. Set, get and delete probe slot by slot, and next steps the
// cursor slot by slot until it stops at a live slot. A set that triggers a rehash also
// clears the new bank and walks the old table, with an insert probe for each live
// entry. After reset a clearing sweep runs over both banks, and full stays high until
// it ends.
module open_addressing_hash_map_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_cmd,
    input  logic [63:0] i_key,
    input  logic [63:0] i_value,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_status,
    output logic [9:0]  o_slot,
    output logic [63:0] o_out_key,
    output logic [63:0] o_out_value,
    output logic [10:0] o_live_entries
);
    logic          front_full;
    logic          init;
    logic          q_wr;
    logic          q_full;
    logic          q_rd;
    logic          q_valid;
    logic          out_valid;
    ohm_pkg::t_req q_wdata;
    ohm_pkg::t_req q_rdata;

    assign full = front_full || init;
    assign empty = !out_valid;

    ohm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push && !full),
        .i_cmd   (i_cmd),
        .i_key   (i_key),
        .i_value (i_value),
        .o_full  (front_full),
        .i_q_full(q_full),
        .o_q_wr  (q_wr),
        .o_q_data(q_wdata)
    );

    ohm_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_wr   (q_wr),
        .i_wdata(q_wdata),
        .o_full (q_full),
        .i_rd   (q_rd),
        .o_valid(q_valid),
        .o_rdata(q_rdata)
    );

    ohm_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .o_init        (init),
        .i_q_valid     (q_valid),
        .i_q_data      (q_rdata),
        .o_q_rd        (q_rd),
        .o_valid       (out_valid),
        .i_pop         (pop),
        .o_status      (o_status),
        .o_slot        (o_slot),
        .o_out_key     (o_out_key),
        .o_out_value   (o_out_value),
        .o_live_entries(o_live_entries)
    );
endmodule

FILE: src/ohm_checker.sv
// Port-level checks for the hash map, bound to the top level.
module ohm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        pop,
    input logic [1:0]  o_status,
    input logic [9:0]  o_slot,
    input logic [63:0] o_out_key,
    input logic [63:0] o_out_value,
    input logic [10:0] o_live_entries
);
    // A failed request never names a slot.
    a_err_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_status != ohm_pkg::ST_OK |-> o_slot == '0)
        else $error("error result carries a slot");

    // An empty-table report comes only with no live entries.
    a_empty_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_status == ohm_pkg::ST_EMPTY |-> o_live_entries == '0)
        else $error("table empty reported with live entries");

    // A missing key returns no value.
    a_miss_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_status == ohm_pkg::ST_MISSING |-> o_out_value == '0 && o_out_key == '0)
        else $error("missing key result carries data");

    // A waiting result keeps its slot and status until it is taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_slot) && $stable(o_status))
        else $error("pending result changed");
endmodule

bind open_addressing_hash_map_top ohm_checker u_ohm_checker (.*);
